// File: sv/ghst_pkg.sv
// Shared types and constants for the generation handle slot table.
// Holds op and status codes, controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ghst_pkg;

	// Operation codes (carried in the input tuser)
	localparam logic [2:0] OP_REGISTER   = 3'd0;
	localparam logic [2:0] OP_UNREGISTER = 3'd1;
	localparam logic [2:0] OP_QUERY      = 3'd2;
	localparam logic [2:0] OP_READ       = 3'd3;
	localparam logic [2:0] OP_WRITE      = 3'd4;
	localparam logic [2:0] OP_FLUSH      = 3'd5;

	// Status codes
	localparam logic [3:0] STS_OK          = 4'd0;
	localparam logic [3:0] STS_INVALID     = 4'd1;
	localparam logic [3:0] STS_NO_SLOT     = 4'd2;
	localparam logic [3:0] STS_STALE       = 4'd3;
	localparam logic [3:0] STS_NOT_READY   = 4'd4;
	localparam logic [3:0] STS_NO_MEDIA    = 4'd5;
	localparam logic [3:0] STS_UNSUPPORTED = 4'd6;
	localparam logic [3:0] STS_RANGE       = 4'd7;
	localparam logic [3:0] STS_READ_ONLY   = 4'd8;
	localparam logic [3:0] STS_TIMEOUT     = 4'd9;
	localparam logic [3:0] STS_IO_ERROR    = 4'd10;
	localparam logic [3:0] STS_EXHAUSTED   = 4'd11;

	// Stream widths
	localparam int unsigned IN_DATA_W  = 160;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 80;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // latch request fields and early result
		logic scan_eval;  // evaluate the slot read during the scan
		logic scan_inc;   // advance the scan index
		logic res_eval;   // evaluate the resolved handle slot
		logic push;       // move result into the output register
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic go_scan;    // incoming request needs the free-slot scan
		logic go_res;     // incoming request needs a handle lookup
		logic scan_done;  // scan found a slot or hit the last one
	} dp_sts_t;

	// Map raw adapter status onto the allowed set
	function automatic logic [3:0] norm_status(input logic [3:0] s);
		logic [3:0] r;
		case (s)
			STS_OK, STS_INVALID, STS_NOT_READY, STS_NO_MEDIA, STS_UNSUPPORTED,
			STS_RANGE, STS_READ_ONLY, STS_TIMEOUT, STS_IO_ERROR: r = s;
			default: r = STS_IO_ERROR;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/ghst_ctrl.sv
// Sequencing state machine for the generation handle slot table.
// Drives datapath commands, the input ready and the output valid.
// Depends on ghst_pkg.
`default_nettype none

module ghst_ctrl
	import ghst_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SCAN_RD = 6'b000010,
		S_SCAN_EV = 6'b000100,
		S_RES_RD  = 6'b001000,
		S_RES_EV  = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.go_scan) begin
						state_d = S_SCAN_RD;
					end else if (sts.go_res) begin
						state_d = S_RES_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_RES_RD: begin
				state_d = S_RES_EV;
			end
			S_RES_EV: begin
				cmd.res_eval = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// wait until the output register is free
				if (!m_valid_q || m_tready) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;

endmodule

`default_nettype wire

// File: sv/ghst_dp.sv
// Datapath of the generation handle slot table: slot store, checks, results.
// Generation and sector count live in memories with one registered read port.
// Depends on ghst_pkg.
`default_nettype none

module ghst_dp
	import ghst_pkg::*;
#(
	parameter int unsigned SLOTS            = 8,
	parameter logic [31:0] GENERATION_LIMIT = 32'hFFFF_FFFF,
	parameter int unsigned SECTOR_BYTES     = 512
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Incoming fields
	logic [2:0]  in_op;
	logic [31:0] in_hslot, in_hgen, in_lba, in_pcount;
	logic        in_ptrs, in_prsv, in_hwr, in_hfl;
	logic [15:0] in_pbytes;
	logic [7:0]  in_pwr;
	logic [3:0]  in_astat;

	assign in_op     = s_tuser[2:0];
	assign in_hslot  = s_tdata[31:0];
	assign in_hgen   = s_tdata[63:32];
	assign in_lba    = s_tdata[95:64];
	assign in_ptrs   = s_tdata[96];
	assign in_pcount = s_tdata[128:97];
	assign in_pbytes = s_tdata[144:129];
	assign in_pwr    = s_tdata[152:145];
	assign in_prsv   = s_tdata[153];
	assign in_hwr    = s_tdata[154];
	assign in_hfl    = s_tdata[155];
	assign in_astat  = s_tdata[159:156];

	// Latched request
	logic [2:0]  op_q;
	logic [31:0] hgen_q, lba_q, pcount_q;
	logic [15:0] pbytes_q;
	logic [7:0]  pwr_q;
	logic        prsv_q, hwr_q, hfl_q;
	logic [3:0]  astat_q;
	logic [IW-1:0] idx_q;
	logic        any_below_q;

	// Slot store
	logic [31:0] gen_mem [SLOTS];
	logic [31:0] cnt_mem [SLOTS];
	logic [31:0] gen_rd_q, cnt_rd_q;
	logic [SLOTS-1:0] gen_vld_q, occ_q, wr_q, hw_q, hf_q;

	// Result and output registers
	logic [3:0]  res_status_q, out_status_q;
	logic [3:0]  res_nslot_q, out_nslot_q;
	logic [31:0] res_ngen_q, out_ngen_q;
	logic [31:0] res_cnt_q, out_cnt_q;
	logic        res_wr_q, out_wr_q;
	logic        res_called_q, out_called_q;

	// Early decode of the incoming request
	logic        needs_res, handle_ok, go_scan;
	logic [31:0] hslot_m1;
	always_comb begin
		needs_res = (in_op == OP_UNREGISTER) || (in_op == OP_FLUSH) ||
			(((in_op == OP_QUERY) || (in_op == OP_READ) || (in_op == OP_WRITE)) && in_ptrs);
		handle_ok = (in_hslot != 32'd0) && (in_hgen != 32'd0) &&
			(in_hgen <= GENERATION_LIMIT) && (in_hslot <= 32'(SLOTS));
		go_scan   = (in_op == OP_REGISTER) && in_ptrs;
		hslot_m1  = in_hslot - 32'd1;
	end

	// Current slot view
	logic [31:0] gen_cur, gen_next, slot_enc;
	logic        below, slot_free, scan_last, geom_ok, reg_ok, hit;
	logic [3:0]  astat_n;
	always_comb begin
		gen_cur   = gen_vld_q[idx_q] ? gen_rd_q : 32'd0;
		gen_next  = gen_cur + 32'd1;
		below     = gen_cur < GENERATION_LIMIT;
		slot_free = !occ_q[idx_q] && below;
		scan_last = (idx_q == IW'(SLOTS - 1));
		astat_n   = norm_status(astat_q);
		geom_ok   = (pcount_q != 32'd0) && (pbytes_q == 16'(SECTOR_BYTES)) &&
			(pwr_q <= 8'd1) && !prsv_q && !((pwr_q == 8'd1) && !hwr_q);
		reg_ok    = slot_free && (astat_n == STS_OK) && geom_ok;
		hit       = occ_q[idx_q] && (gen_cur == hgen_q);
		slot_enc  = 32'(idx_q) + 32'd1;
	end

	// Handle operation outcome
	logic [3:0]  ho_status;
	logic        ho_called, ho_query, ho_free;
	always_comb begin
		ho_status = STS_STALE;
		ho_called = 1'b0;
		ho_query  = 1'b0;
		ho_free   = 1'b0;
		if (hit) begin
			case (op_q)
				OP_UNREGISTER, OP_FLUSH: begin
					ho_status = STS_OK;
					if (hf_q[idx_q]) begin
						ho_called = 1'b1;
						ho_status = astat_n;
					end
					ho_free = (op_q == OP_UNREGISTER) &&
						(!hf_q[idx_q] || (astat_n == STS_OK));
				end
				OP_QUERY: begin
					ho_status = STS_OK;
					ho_query  = 1'b1;
				end
				OP_READ, OP_WRITE: begin
					if (lba_q >= cnt_rd_q) begin
						ho_status = STS_RANGE;
					end else if ((op_q == OP_WRITE) && (!wr_q[idx_q] || !hw_q[idx_q])) begin
						ho_status = STS_READ_ONLY;
					end else begin
						ho_called = 1'b1;
						ho_status = astat_n;
					end
				end
				default: begin
					ho_status = STS_INVALID;
				end
			endcase
		end
	end

	assign sts.go_scan   = go_scan;
	assign sts.go_res    = needs_res && handle_ok;
	assign sts.scan_done = slot_free || scan_last;

	// Request latch and slot index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			hgen_q   <= in_hgen;
			lba_q    <= in_lba;
			pcount_q <= in_pcount;
			pbytes_q <= in_pbytes;
			pwr_q    <= in_pwr;
			prsv_q   <= in_prsv;
			hwr_q    <= in_hwr;
			hfl_q    <= in_hfl;
			astat_q  <= in_astat;
			idx_q    <= go_scan ? '0 : hslot_m1[IW-1:0];
		end else if (cmd.scan_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// Memories: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_eval && reg_ok) begin
			gen_mem[idx_q] <= gen_next;
			cnt_mem[idx_q] <= pcount_q;
		end
		gen_rd_q <= gen_mem[idx_q];
		cnt_rd_q <= cnt_mem[idx_q];
	end

	// Per-slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_vld_q <= '0;
			occ_q     <= '0;
			wr_q      <= '0;
			hw_q      <= '0;
			hf_q      <= '0;
		end else if (cmd.scan_eval && reg_ok) begin
			gen_vld_q[idx_q] <= 1'b1;
			occ_q[idx_q]     <= 1'b1;
			wr_q[idx_q]      <= (pwr_q == 8'd1);
			hw_q[idx_q]      <= hwr_q;
			hf_q[idx_q]      <= hfl_q;
		end else if (cmd.res_eval && ho_free) begin
			occ_q[idx_q] <= 1'b0;
			wr_q[idx_q]  <= 1'b0;
			hw_q[idx_q]  <= 1'b0;
			hf_q[idx_q]  <= 1'b0;
		end
	end

	// Track whether any scanned slot still has generations left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_below_q <= 1'b0;
		end else if (cmd.load) begin
			any_below_q <= 1'b0;
		end else if (cmd.scan_eval) begin
			any_below_q <= any_below_q | below;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= needs_res ? STS_STALE : STS_INVALID;
			res_nslot_q  <= 4'd0;
			res_ngen_q   <= 32'd0;
			res_cnt_q    <= 32'd0;
			res_wr_q     <= 1'b0;
			res_called_q <= 1'b0;
		end else if (cmd.scan_eval) begin
			if (slot_free) begin
				res_called_q <= 1'b1;
				if (reg_ok) begin
					res_status_q <= STS_OK;
					res_nslot_q  <= slot_enc[3:0];
					res_ngen_q   <= gen_next;
				end else if (astat_n == STS_OK) begin
					res_status_q <= STS_UNSUPPORTED;
				end else begin
					res_status_q <= astat_n;
				end
			end else if (scan_last) begin
				res_status_q <= (any_below_q || below) ? STS_NO_SLOT : STS_EXHAUSTED;
			end
		end else if (cmd.res_eval) begin
			res_status_q <= ho_status;
			res_called_q <= ho_called;
			res_cnt_q    <= ho_query ? cnt_rd_q : 32'd0;
			res_wr_q     <= ho_query & wr_q[idx_q];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_nslot_q  <= res_nslot_q;
			out_ngen_q   <= res_ngen_q;
			out_cnt_q    <= res_cnt_q;
			out_wr_q     <= res_wr_q;
			out_called_q <= res_called_q;
		end
	end

	assign m_tdata = {6'd0, out_called_q, out_wr_q, out_cnt_q, out_ngen_q,
		out_nslot_q, out_status_q};

endmodule

`default_nettype wire

// File: sv/generation_handle_slot_table_top.sv
// Sequence from accept to result valid: requests rejected at decode go straight
// to the done state, handle operations pass a read and an evaluate state, and a
// register scans k slots (1..SLOTS), each with a read state and an evaluate state.
// A new request is taken in the cycle after the previous result is loaded.
// Reset: arst_n clears all slots (free, generation zero) and the controller.
// Top level of the generation handle slot table; depends on ghst_pkg,
// ghst_ctrl and ghst_dp.
`default_nettype none

module generation_handle_slot_table_top
	import ghst_pkg::*;
#(
	parameter int unsigned SLOTS            = 8,
	parameter logic [31:0] GENERATION_LIMIT = 32'hFFFF_FFFF,
	parameter int unsigned SECTOR_BYTES     = 512
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// handle_slot[31:0], handle_generation[63:32], lba[95:64], pointers_valid[96],
	// probe_sector_count[128:97], probe_sector_bytes[144:129],
	// probe_writable[152:145], probe_reserved_nonzero[153], has_write_op[154],
	// has_flush_op[155], adapter_status[159:156]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[2:0]
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// status[3:0], new_handle_slot[7:4], new_handle_generation[39:8],
	// sector_count_out[71:40], writable_out[72], adapter_called[73], zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ghst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ghst_dp #(
		.SLOTS            (SLOTS),
		.GENERATION_LIMIT (GENERATION_LIMIT),
		.SECTOR_BYTES     (SECTOR_BYTES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_axis_tdata),
		.s_tuser (s_axis_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_axis_tdata)
	);

`ifndef SYNTHESIS
	// Block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("ready high right after accepting a request");

	// A new handle only comes with ok status and a nonzero generation
	a_handle_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[7:4] != 4'd0)) |->
		((m_axis_tdata[3:0] == STS_OK) && (m_axis_tdata[39:8] != 32'd0)))
		else $error("new handle without ok status");

	// Adapter codes never map onto the table-only status values
	a_called_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[73]) |->
		((m_axis_tdata[3:0] != STS_STALE) && (m_axis_tdata[3:0] != STS_NO_SLOT) &&
		 (m_axis_tdata[3:0] != STS_EXHAUSTED)))
		else $error("adapter flagged on a table-level rejection");

	// Geometry is only reported on success
	a_query_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[71:40] != 32'd0)) |->
		(m_axis_tdata[3:0] == STS_OK))
		else $error("sector count reported without ok status");
`endif

endmodule

`default_nettype wire
